@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the line follower RTL. Define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset
`define LFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define LFPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LFPD_ASSERT(lbl, prop, msg)
`define LFPD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ src/lfpd_pkg.sv @@
// ---------------------------------------------------------------------------
// lfpd_pkg
// Types and constants of the line follower centroid, PID and drive block.
// ---------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int SAMPLE_W    = 10;  // sensor sample and clamp width
  localparam int NUM_SENSORS = 7;
  localparam int SUM_W       = 13;  // plain sum of seven clamped samples
  localparam int WSUM_W      = 14;  // weighted sum, signed
  localparam int GAIN_W      = 8;
  localparam int MUL_B_W     = 16;
  localparam int PROD_W      = GAIN_W + 1 + MUL_B_W;
  localparam int ACC_W       = 26;
  localparam int QUOT_W      = 10;  // quotient magnitude stays below 1024
  localparam int REM_W       = SUM_W + 1;
  localparam int DIV_ITERS   = QUOT_W;
  localparam int ERR_W       = 11;
  localparam int DERIV_W     = 12;
  localparam int INTEG_W     = 16;
  localparam int CTRL_W      = 8;
  localparam int DUTY_W      = 10;
  localparam int DUTY_RAW_W  = DUTY_W + 2;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;

  localparam logic signed [ACC_W-1:0] ACC_CTRL_MIN = -26'sd128;
  localparam logic signed [ACC_W-1:0] ACC_CTRL_MAX = 26'sd127;

  localparam logic [CNT_W-1:0] ACCUM_LAST = CNT_W'(NUM_SENSORS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_ITERS - 1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY      = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
  } in_item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  position_error;
    logic signed [CTRL_W-1:0] control_value;
    logic [DUTY_W-1:0]        left_duty;
    logic [DUTY_W-1:0]        right_duty;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] clamp_low;
    logic [SAMPLE_W-1:0] clamp_high;
    logic [GAIN_W-1:0]   position_scale;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [DUTY_W-1:0]   base_duty;
  } cfg_t;

  typedef struct packed {
    logic start;      // item taken this cycle
    logic res_ready;  // output register free this cycle
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;       // result moves to the output register
  } core_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SCALE,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_DIV_SIGN,
    ST_PID_INT,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_CTRL,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ src/line_follow_pid_drive.sv @@
// ---------------------------------------------------------------------------
// line_follow_pid_drive
// Line sensor centroid, PID step and differential drive duties, computed
// on one shared multiplier and a bit-serial divider under a sequencer.
//
//   Channel  Signals                              Direction
//   in       in_valid, in_ready, in_data         scan of seven samples in
//   out      out_valid, out_ready, out_data      error, control, duties out
//   cfg      cfg_valid, cfg_ready, cfg_index,    register write in
//            cfg_data
//
// An item passes through seven sample steps, one scale multiply, ten divide
// steps and the PID and duty steps; the next item is taken only once the
// sequencer is back in idle. A scan whose clamped samples sum to zero skips
// the divider.
// The result sits in an output register, so the next item is taken while
// it waits; a full register stalls the sequencer at its last step.
// Synchronous reset restores the register defaults and clears the integral
// and the previous error. Configuration writes are always taken.
// ---------------------------------------------------------------------------
`default_nettype none

module line_follow_pid_drive (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire lfpd_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output lfpd_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lfpd_pkg::cfg_t       cfg;
  lfpd_pkg::core_ctl_t  ctl;
  lfpd_pkg::core_sts_t  sts;
  lfpd_pkg::out_item_t  res;

  assign cfg_ready     = 1'b1;
  assign in_ready      = sts.idle;
  assign ctl.start     = in_valid && in_ready;
  assign ctl.res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clamp_low      <= 10'd50;
      cfg.clamp_high     <= 10'd650;
      cfg.position_scale <= 8'd17;
      cfg.gain_p         <= 8'd128;
      cfg.gain_i         <= 8'd0;
      cfg.gain_d         <= 8'd96;
      cfg.base_duty      <= 10'd150;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lfpd_pkg::REG_CLAMP_LOW:      cfg.clamp_low      <= cfg_data;
        lfpd_pkg::REG_CLAMP_HIGH:     cfg.clamp_high     <= cfg_data;
        lfpd_pkg::REG_POSITION_SCALE: cfg.position_scale <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_GAIN_P:         cfg.gain_p         <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_GAIN_I:         cfg.gain_i         <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_GAIN_D:         cfg.gain_d         <= cfg_data[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_BASE_DUTY:      cfg.base_duty      <= cfg_data;
        default:                      cfg <= cfg;  // drop writes past the list
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      out_data <= res;
    end
  end

  lfpd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ctl     (ctl),
    .in_data (in_data),
    .sts     (sts),
    .res     (res)
  );

endmodule

`default_nettype wire

@@ src/lfpd_core.sv @@
// ---------------------------------------------------------------------------
// lfpd_core
// Sequenced datapath: sample window and sums, scale multiply, restoring
// divide, PID update on one shared multiplier, and duty clamping.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfpd_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire lfpd_pkg::cfg_t       cfg,
  input  wire lfpd_pkg::core_ctl_t  ctl,
  input  wire lfpd_pkg::in_item_t   in_data,
  output lfpd_pkg::core_sts_t       sts,
  output lfpd_pkg::out_item_t       res
);

  lfpd_pkg::state_t state, state_next;

  logic [lfpd_pkg::CNT_W-1:0]            cnt;
  lfpd_pkg::in_item_t                    scan;
  logic signed [lfpd_pkg::WSUM_W-1:0]    wsum;
  logic [lfpd_pkg::SUM_W-1:0]            sum;
  logic signed [lfpd_pkg::ACC_W-1:0]     acc;
  logic                                  neg;
  logic [lfpd_pkg::REM_W-1:0]            rem;
  logic [lfpd_pkg::QUOT_W-1:0]           quot;
  logic signed [lfpd_pkg::ERR_W-1:0]     err;
  logic signed [lfpd_pkg::ERR_W-1:0]     last_error;
  logic signed [lfpd_pkg::INTEG_W-1:0]   integral_sum;
  logic signed [lfpd_pkg::CTRL_W-1:0]    ctrl;

  // Combinational helpers
  logic [lfpd_pkg::SAMPLE_W-1:0]         raw;
  logic [lfpd_pkg::SAMPLE_W-1:0]         smp;
  logic [lfpd_pkg::SAMPLE_W+1:0]         smp3;
  logic signed [lfpd_pkg::WSUM_W-1:0]    term;
  logic [lfpd_pkg::GAIN_W-1:0]           mul_a;
  logic signed [lfpd_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [lfpd_pkg::PROD_W-1:0]    mul_p;
  logic [lfpd_pkg::ACC_W-1:0]            mag;
  logic [lfpd_pkg::REM_W-1:0]            shifted;
  logic [lfpd_pkg::REM_W:0]              diff;
  logic signed [lfpd_pkg::ERR_W-1:0]     quot_ext;
  logic signed [lfpd_pkg::DERIV_W-1:0]   deriv;
  logic signed [lfpd_pkg::INTEG_W:0]     integ_sum;
  logic signed [lfpd_pkg::ACC_W-1:0]     acc_adj;
  logic signed [lfpd_pkg::ACC_W-1:0]     acc_shf;
  logic signed [lfpd_pkg::DUTY_RAW_W-1:0] left_raw;
  logic signed [lfpd_pkg::DUTY_RAW_W-1:0] right_raw;

  // Sample of the current step
  always_comb begin
    case (cnt[2:0])
      3'd0:    raw = scan.sample_0;
      3'd1:    raw = scan.sample_1;
      3'd2:    raw = scan.sample_2;
      3'd3:    raw = scan.sample_3;
      3'd4:    raw = scan.sample_4;
      3'd5:    raw = scan.sample_5;
      3'd6:    raw = scan.sample_6;
      default: raw = '0;
    endcase
  end

  // Upper clamp wins when the window is inverted
  always_comb begin
    if (raw > cfg.clamp_high) begin
      smp = cfg.clamp_high;
    end else if (raw < cfg.clamp_low) begin
      smp = cfg.clamp_low;
    end else begin
      smp = raw;
    end
    smp3 = {2'b00, smp} + {1'b0, smp, 1'b0};
  end

  always_comb begin
    case (cnt[2:0])
      3'd0:    term = -lfpd_pkg::WSUM_W'(smp3);
      3'd1:    term = -lfpd_pkg::WSUM_W'({smp, 1'b0});
      3'd2:    term = -lfpd_pkg::WSUM_W'(smp);
      3'd4:    term = lfpd_pkg::WSUM_W'(smp);
      3'd5:    term = lfpd_pkg::WSUM_W'({smp, 1'b0});
      3'd6:    term = lfpd_pkg::WSUM_W'(smp3);
      default: term = '0;
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    mag      = acc[lfpd_pkg::ACC_W-1] ? lfpd_pkg::ACC_W'(-acc) : lfpd_pkg::ACC_W'(acc);
    shifted  = {rem[lfpd_pkg::REM_W-2:0], quot[lfpd_pkg::QUOT_W-1]};
    diff     = {1'b0, shifted} - {2'b00, sum};
    quot_ext = $signed({1'b0, quot});
    deriv    = lfpd_pkg::DERIV_W'(err) - lfpd_pkg::DERIV_W'(last_error);
    integ_sum = (lfpd_pkg::INTEG_W + 1)'(integral_sum) + (lfpd_pkg::INTEG_W + 1)'(err);
    // Truncate toward zero: bias negative values before the shift
    acc_adj  = acc + (acc[lfpd_pkg::ACC_W-1] ? lfpd_pkg::ACC_W'(15) : '0);
    acc_shf  = acc_adj >>> 4;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lfpd_pkg::ST_IDLE:     if (ctl.start) state_next = lfpd_pkg::ST_ACCUM;
      lfpd_pkg::ST_ACCUM:    if (cnt == lfpd_pkg::ACCUM_LAST) state_next = lfpd_pkg::ST_SCALE;
      lfpd_pkg::ST_SCALE:    state_next = lfpd_pkg::ST_DIV_INIT;
      lfpd_pkg::ST_DIV_INIT: begin
        state_next = (sum == '0) ? lfpd_pkg::ST_PID_INT : lfpd_pkg::ST_DIVIDE;
      end
      lfpd_pkg::ST_DIVIDE:   if (cnt == lfpd_pkg::DIV_LAST) state_next = lfpd_pkg::ST_DIV_SIGN;
      lfpd_pkg::ST_DIV_SIGN: state_next = lfpd_pkg::ST_PID_INT;
      lfpd_pkg::ST_PID_INT:  state_next = lfpd_pkg::ST_MUL_P;
      lfpd_pkg::ST_MUL_P:    state_next = lfpd_pkg::ST_MUL_I;
      lfpd_pkg::ST_MUL_I:    state_next = lfpd_pkg::ST_MUL_D;
      lfpd_pkg::ST_MUL_D:    state_next = lfpd_pkg::ST_CTRL;
      lfpd_pkg::ST_CTRL:     state_next = lfpd_pkg::ST_FINISH;
      lfpd_pkg::ST_FINISH:   if (ctl.res_ready) state_next = lfpd_pkg::ST_IDLE;
      default:               state_next = lfpd_pkg::ST_IDLE;
    endcase
  end

  // Outputs and multiplier operands
  always_comb begin
    sts.idle = (state == lfpd_pkg::ST_IDLE);
    sts.done = (state == lfpd_pkg::ST_FINISH) && ctl.res_ready;
    case (state)
      lfpd_pkg::ST_SCALE: begin
        mul_a = cfg.position_scale;
        mul_b = lfpd_pkg::MUL_B_W'(wsum);
      end
      lfpd_pkg::ST_MUL_P: begin
        mul_a = cfg.gain_p;
        mul_b = lfpd_pkg::MUL_B_W'(err);
      end
      lfpd_pkg::ST_MUL_I: begin
        mul_a = cfg.gain_i;
        mul_b = lfpd_pkg::MUL_B_W'(integral_sum);
      end
      lfpd_pkg::ST_MUL_D: begin
        mul_a = cfg.gain_d;
        mul_b = lfpd_pkg::MUL_B_W'(deriv);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    left_raw  = $signed({2'b00, cfg.base_duty}) - lfpd_pkg::DUTY_RAW_W'(ctrl);
    right_raw = $signed({2'b00, cfg.base_duty}) + lfpd_pkg::DUTY_RAW_W'(ctrl);

    res.position_error = err;
    res.control_value  = ctrl;
    if (left_raw < 0) begin
      res.left_duty = '0;
    end else if (left_raw > $signed({2'b00, lfpd_pkg::DUTY_MAX})) begin
      res.left_duty = lfpd_pkg::DUTY_MAX;
    end else begin
      res.left_duty = left_raw[lfpd_pkg::DUTY_W-1:0];
    end
    if (right_raw < 0) begin
      res.right_duty = '0;
    end else if (right_raw > $signed({2'b00, lfpd_pkg::DUTY_MAX})) begin
      res.right_duty = lfpd_pkg::DUTY_MAX;
    end else begin
      res.right_duty = right_raw[lfpd_pkg::DUTY_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lfpd_pkg::ST_IDLE;
      cnt          <= '0;
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      state <= state_next;
      case (state)
        lfpd_pkg::ST_IDLE:     cnt <= '0;
        lfpd_pkg::ST_ACCUM:    cnt <= (cnt == lfpd_pkg::ACCUM_LAST) ? '0 : cnt + 1'b1;
        lfpd_pkg::ST_DIVIDE:   cnt <= cnt + 1'b1;
        lfpd_pkg::ST_PID_INT: begin
          if (integ_sum[lfpd_pkg::INTEG_W] != integ_sum[lfpd_pkg::INTEG_W-1]) begin
            integral_sum <= integ_sum[lfpd_pkg::INTEG_W] ? 16'sh8000 : 16'sh7FFF;
          end else begin
            integral_sum <= integ_sum[lfpd_pkg::INTEG_W-1:0];
          end
        end
        lfpd_pkg::ST_MUL_D:    last_error <= err;
        default:               cnt <= cnt;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      lfpd_pkg::ST_IDLE: begin
        if (ctl.start) begin
          scan <= in_data;
        end
        wsum <= '0;
        sum  <= '0;
      end
      lfpd_pkg::ST_ACCUM: begin
        wsum <= wsum + term;
        sum  <= sum + lfpd_pkg::SUM_W'(smp);
      end
      lfpd_pkg::ST_SCALE: acc <= lfpd_pkg::ACC_W'(mul_p);
      lfpd_pkg::ST_DIV_INIT: begin
        neg  <= acc[lfpd_pkg::ACC_W-1];
        // Quotient fits ten bits, so the upper bits start as the remainder
        rem  <= lfpd_pkg::REM_W'(mag[lfpd_pkg::ACC_W-1:lfpd_pkg::QUOT_W]);
        quot <= mag[lfpd_pkg::QUOT_W-1:0];
        if (sum == '0) begin
          err <= '0;
        end
      end
      lfpd_pkg::ST_DIVIDE: begin
        if (!diff[lfpd_pkg::REM_W]) begin
          rem  <= diff[lfpd_pkg::REM_W-1:0];
          quot <= {quot[lfpd_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[lfpd_pkg::QUOT_W-2:0], 1'b0};
        end
      end
      lfpd_pkg::ST_DIV_SIGN: err <= neg ? -quot_ext : quot_ext;
      lfpd_pkg::ST_MUL_P:    acc <= lfpd_pkg::ACC_W'(mul_p);
      lfpd_pkg::ST_MUL_I:    acc <= acc + lfpd_pkg::ACC_W'(mul_p);
      lfpd_pkg::ST_MUL_D:    acc <= acc + lfpd_pkg::ACC_W'(mul_p);
      lfpd_pkg::ST_CTRL: begin
        if (acc_shf < lfpd_pkg::ACC_CTRL_MIN) begin
          ctrl <= -8'sd128;
        end else if (acc_shf > lfpd_pkg::ACC_CTRL_MAX) begin
          ctrl <= 8'sd127;
        end else begin
          ctrl <= acc_shf[lfpd_pkg::CTRL_W-1:0];
        end
      end
      default: acc <= acc;
    endcase
  end

  `LFPD_ASSERT(a_start_when_idle, ctl.start |-> state == lfpd_pkg::ST_IDLE, "item taken while busy")
  `LFPD_ASSERT(a_rem_below_divisor, state == lfpd_pkg::ST_DIVIDE |-> rem < lfpd_pkg::REM_W'(sum), "divider remainder not below sum")
  `LFPD_ASSERT(a_err_range, state == lfpd_pkg::ST_PID_INT |-> (err <= 11'sd765) && (err >= -11'sd765), "position error out of range")
  `LFPD_ASSERT(a_result_held, (state == lfpd_pkg::ST_FINISH) && !ctl.res_ready |=> $stable(res), "result moved while waiting")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for line_follow_pid_drive. Scans go in through a
// valid/ready driver fed from a queue, and results are checked field by field
// against a predictor of the centroid, PID and duty maths. Both sides idle in
// random bursts unless a phase makes them calm. Registers change only between
// phases, once the block has drained.
// ---------------------------------------------------------------------------
module tb;
  import lfpd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // no register behind it
  localparam cfg_t REGS_AT_RESET = '{clamp_low: 10'd50, clamp_high: 10'd650,
                                     position_scale: 8'd17, gain_p: 8'd128,
                                     gain_i: 8'd0, gain_d: 8'd96,
                                     base_duty: 10'd150};

  typedef int scan_vals_t [NUM_SENSORS];

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t      regs = REGS_AT_RESET;
  int        integ = 0;
  int        prev_err = 0;
  in_item_t  scan_queue [$];
  out_item_t expected_drive [$];
  int        scans_sent = 0;
  int        scans_taken = 0;
  int        fails = 0;
  int        cycles = 0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;

  line_follow_pid_drive DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expected drive for one scan; advances the integral and the previous error
  function automatic out_item_t drive_step(in_item_t scan);
    scan_vals_t s;
    int        lo, hi, x, wsum, total, err, deriv, ctrl, scale, gp, gi, gd, bd;
    longint    acc;
    out_item_t r;
    s = '{scan.sample_0, scan.sample_1, scan.sample_2, scan.sample_3,
          scan.sample_4, scan.sample_5, scan.sample_6};
    lo = regs.clamp_low;
    hi = regs.clamp_high;
    scale = regs.position_scale;
    gp = regs.gain_p;
    gi = regs.gain_i;
    gd = regs.gain_d;
    bd = regs.base_duty;
    wsum = 0;
    total = 0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      x = s[i];
      // upper bound wins when the window is inverted
      if (x > hi) x = hi;
      else if (x < lo) x = lo;
      wsum += (i - 3) * x;
      total += x;
    end
    err = (total != 0) ? (scale * wsum) / total : 0;
    integ = int'(clip(longint'(integ) + err, -32768, 32767));
    deriv = err - prev_err;
    acc = longint'(gp) * err + longint'(gi) * integ + longint'(gd) * deriv;
    ctrl = int'(clip(acc / 16, -128, 127));
    prev_err = err;
    r.position_error = ERR_W'(err);
    r.control_value  = CTRL_W'(ctrl);
    r.left_duty      = DUTY_W'(clip(bd - ctrl, 0, 1000));
    r.right_duty     = DUTY_W'(clip(bd + ctrl, 0, 1000));
    return r;
  endfunction

  function automatic void check_field(string field, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  function automatic in_item_t pack_scan(scan_vals_t v);
    in_item_t r;
    r.sample_0 = SAMPLE_W'(v[0]);
    r.sample_1 = SAMPLE_W'(v[1]);
    r.sample_2 = SAMPLE_W'(v[2]);
    r.sample_3 = SAMPLE_W'(v[3]);
    r.sample_4 = SAMPLE_W'(v[4]);
    r.sample_5 = SAMPLE_W'(v[5]);
    r.sample_6 = SAMPLE_W'(v[6]);
    return r;
  endfunction

  // A line under the array: a bump of height peak centred at pos (ten per sensor)
  function automatic in_item_t line_scan(int pos, int peak, int floor_lvl);
    scan_vals_t v;
    int d;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      d = 10 * i - pos;
      if (d < 0) d = -d;
      v[i] = floor_lvl + $urandom_range(0, 40) + ((d < 12) ? peak * (12 - d) / 12 : 0);
      if (v[i] > 1023) v[i] = 1023;
    end
    return pack_scan(v);
  endfunction

  function automatic in_item_t noise_scan();
    scan_vals_t v;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      case ($urandom_range(0, 3))
        0:       v[i] = 0;
        1:       v[i] = 1023;
        default: v[i] = $urandom_range(0, 1023);
      endcase
    end
    return pack_scan(v);
  endfunction

  task automatic queue_scan(in_item_t s);
    scan_queue.push_back(s);
    scans_sent++;
  endtask

  // Runs of a drifting line with random content, broken up by noise
  task automatic fill_random(int n);
    int left, run, pos, drift, peak, floor_lvl;
    left = n;
    while (left > 0) begin
      run = $urandom_range(5, 40);
      if (run > left) run = left;
      if ($urandom_range(0, 9) < 7) begin
        pos = $urandom_range(0, 80) - 10;
        drift = $urandom_range(0, 4) - 2;
        peak = $urandom_range(100, 1023);
        floor_lvl = $urandom_range(0, 200);
        repeat (run) begin
          queue_scan(line_scan(pos, peak, floor_lvl));
          pos = int'(clip(pos + drift + int'($urandom_range(0, 2)) - 1, -10, 70));
        end
      end else begin
        repeat (run) queue_scan(noise_scan());
      end
      left -= run;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CLAMP_LOW:      regs.clamp_low = val;
      REG_CLAMP_HIGH:     regs.clamp_high = val;
      REG_POSITION_SCALE: regs.position_scale = val[GAIN_W-1:0];
      REG_GAIN_P:         regs.gain_p = val[GAIN_W-1:0];
      REG_GAIN_I:         regs.gain_i = val[GAIN_W-1:0];
      REG_GAIN_D:         regs.gain_d = val[GAIN_W-1:0];
      REG_BASE_DUTY:      regs.base_duty = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(int lo, int hi, int scale, int gp, int gi, int gd, int bd);
    write_reg(REG_CLAMP_LOW, CFG_DATA_W'(lo));
    write_reg(REG_CLAMP_HIGH, CFG_DATA_W'(hi));
    write_reg(REG_POSITION_SCALE, CFG_DATA_W'(scale));
    write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
    write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
    write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
    write_reg(REG_BASE_DUTY, CFG_DATA_W'(bd));
  endtask

  // Hold until every scan is taken and every result is back, then let it settle
  task automatic drain();
    do @(negedge clk); while (scans_taken != scans_sent || expected_drive.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_scans
    int       send_gap;
    logic     next_valid;
    in_item_t next_scan;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      next_scan = in_data;
      if (in_valid && in_ready) begin
        expected_drive.push_back(drive_step(in_data));
        scans_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid && scan_queue.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!send_calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 13);
        end else begin
          next_scan = scan_queue.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
      in_data  <= next_scan;
    end
  end

  always @(posedge clk) begin : watch_drive
    int        stall;
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          $display("%0t result with none expected: expected nothing, got %p", $time, out_data);
          fails++;
        end else begin
          want = expected_drive.pop_front();
          check_field("position_error", want.position_error, out_data.position_error);
          check_field("control_value", want.control_value, out_data.control_value);
          check_field("left_duty", want.left_duty, out_data.left_duty);
          check_field("right_duty", want.right_duty, out_data.right_duty);
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!recv_calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed scans under the reset window of 50..650
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 0}));
    queue_scan(pack_scan('{1023, 1023, 1023, 1023, 1023, 1023, 1023}));
    queue_scan(pack_scan('{1023, 0, 0, 0, 0, 0, 0}));
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 1023}));
    queue_scan(pack_scan('{0, 0, 0, 1023, 0, 0, 0}));
    queue_scan(pack_scan('{682, 682, 682, 682, 682, 682, 682}));
    queue_scan(pack_scan('{341, 341, 341, 341, 341, 341, 341}));
    queue_scan(pack_scan('{0, 170, 340, 510, 680, 850, 1023}));
    queue_scan(pack_scan('{1023, 850, 680, 510, 340, 170, 0}));
    queue_scan(pack_scan('{49, 50, 51, 649, 650, 651, 49}));
    queue_scan(pack_scan('{651, 650, 649, 51, 50, 49, 651}));
    queue_scan(pack_scan('{1023, 1023, 0, 0, 0, 0, 0}));
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 1023, 1023}));
    queue_scan(pack_scan('{900, 0, 0, 0, 0, 0, 0}));
    queue_scan(pack_scan('{900, 0, 0, 0, 0, 0, 0}));
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 900}));
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 900}));
    queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 0}));
    fill_random(30);
    drain();

    // Widest window and largest gains: drive the integral into saturation
    configure(0, 1023, 255, 255, 255, 255, 1000);
    fill_random(45);
    repeat (3) queue_scan(pack_scan('{0, 0, 0, 0, 0, 0, 0}));
    fill_random(45);
    drain();

    // Everything at zero: every sum is zero
    send_calm = ($urandom_range(0, 3) == 0);
    recv_calm = ($urandom_range(0, 3) == 0);
    configure(0, 0, 0, 0, 0, 0, 0);
    write_reg(REG_NONE, 10'h3ff);
    fill_random(20);
    drain();

    // Inverted window and a base duty past the duty ceiling
    configure(900, 100, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 1023), $urandom_range(0, 1023), 1023);
    fill_random(60);
    drain();

    repeat (5) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      configure($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023));
      if ($urandom_range(0, 1) == 1) write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 1023)));
      fill_random(100);
      drain();
    end

    // Final stretch at full rate on both sides
    send_calm = 1'b1;
    recv_calm = 1'b1;
    configure($urandom_range(0, 300), $urandom_range(400, 1023), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 1023));
    fill_random(60);
    drain();

    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/lfpd_pkg.sv
src/lfpd_core.sv
src/line_follow_pid_drive.sv
verif/tb.sv
